>>> rtl/bfha_pkg.sv
package bfha_pkg;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_RD,
    ST_A_EV,
    ST_A_FIN,
    ST_A_SPLIT,
    ST_F_RD,
    ST_F_EV,
    ST_C_RD,
    ST_C_EV,
    ST_C_NX,
    ST_DONE
  } state_e;

  localparam logic       REQ_ALLOC = 1'b0;
  localparam logic       REQ_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  localparam int unsigned HEAP_FLOOR_BYTES = 4096;
  localparam int unsigned HEAP_MAX_BYTES   = 16384;

endpackage

>>> rtl/bfha_store.sv
module bfha_store #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/best_fit_heap_allocator.sv
// Best-fit heap allocator over a chain of chunk headers.
// Request channel (req_*): req_type_i selects allocate or free; req_size_i is the
// byte count of an allocate, free_offset_i the data offset to release.
// Response channel (rsp_*): data_offset_o and status_o, one beat per request.
// Config channel (cfg_*): heap_size_i sets the heap length and rebuilds the heap
// as one free chunk; take it only while no request is outstanding.
// An allocate reads every header on the chain, then marks the best fit taken
// and, when the rest is large enough, writes a split header; a zero-size
// allocate returns no-fit without a walk. A free walks the chain up to the
// target and marks it free, then walks from the start, merging each free chunk
// with free chunks after it. Chunks are at least 12 bytes. The chunk store has
// a single read port, so headers are read one at a time. One request is in
// work at a time.
// Reset and every config write enter ST_INIT to write the first header, with
// req_ready_o low. A result held by a stalled receiver does not block taking
// the next request; that request waits at its end until the response beat goes.
module best_fit_heap_allocator #(
  parameter int unsigned MIN_SPLIT_BYTES = 32,
  parameter int unsigned HEADER_BYTES    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic        req_type_i,
  input  logic [14:0] req_size_i,
  input  logic [13:0] free_offset_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output logic [13:0] data_offset_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] heap_size_i
);

  localparam int unsigned PW = $clog2(bfha_pkg::HEAP_MAX_BYTES) + 1;
  localparam int unsigned AW = $clog2(bfha_pkg::HEAP_MAX_BYTES / 4);
  localparam int unsigned CW = (PW + 1 > 18) ? PW + 1 : 18;
  localparam int unsigned DW = PW + 1;

  bfha_pkg::state_e state_q, state_d;

  logic [PW-1:0] heap_q, heap_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] cur_q, cur_d;
  logic [PW-1:0] best_q, best_d;
  logic [PW-1:0] blen_q, blen_d;
  logic          found_q, found_d;
  logic [CW-1:0] need_q, need_d;
  logic          rsp_valid_q, rsp_valid_d;
  logic [13:0]   rsp_off_q, rsp_off_d;
  logic [1:0]    rsp_st_q, rsp_st_d;
  logic [13:0]   res_off_q, res_off_d;
  logic [1:0]    res_st_q, res_st_d;
  logic [13:0]   foff_q, foff_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  logic [CW-1:0] r_len, r_pos, r_heap, r_next, r_rem, r_nrem, r_need, r_norm;
  logic [CW-1:0] r_split;
  logic          r_free, r_bad, r_nbad;
  logic          cfg_acc, req_acc;

  bfha_store #(.AW(AW), .DW(DW)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign req_acc = req_valid_i && req_ready_o;

  always_comb begin
    r_len  = CW'(rdata[PW-1:0]);
    r_free = rdata[PW];
    r_pos  = CW'(pos_q);
    r_heap = CW'(heap_q);
    r_next = r_pos + r_len;
    r_rem  = r_heap - r_pos;
    r_bad  = (r_len < CW'(4)) || (r_len > r_rem);
    // next chunk check in merge walk: pos + cur is its start
    r_nrem = r_heap - (r_pos + CW'(cur_q));
    r_nbad = (r_len < CW'(4)) || (r_len > r_nrem);
    r_split = CW'(best_q) + need_q;
    r_need = ((CW'(req_size_i) + CW'(3)) & ~CW'(3)) + CW'(HEADER_BYTES);
    r_need = (r_need + CW'(3)) & ~CW'(3);
    r_norm = CW'(heap_size_i);
    if (r_norm < CW'(bfha_pkg::HEAP_FLOOR_BYTES)) r_norm = CW'(bfha_pkg::HEAP_FLOOR_BYTES);
    r_norm = (r_norm + CW'(3)) & ~CW'(3);
    if (r_norm > CW'(bfha_pkg::HEAP_MAX_BYTES)) begin
      r_norm = CW'(bfha_pkg::HEAP_MAX_BYTES) & ~CW'(3);
    end
  end

  // next state and datapath registers
  always_comb begin
    state_d     = state_q;
    heap_d      = heap_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    best_d      = best_q;
    blen_d      = blen_q;
    found_d     = found_q;
    need_d      = need_q;
    res_off_d   = res_off_q;
    res_st_d    = res_st_q;
    foff_d      = foff_q;
    rsp_valid_d = rsp_valid_q;
    rsp_off_d   = rsp_off_q;
    rsp_st_d    = rsp_st_q;
    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;
    unique case (state_q)
      bfha_pkg::ST_INIT: state_d = bfha_pkg::ST_IDLE;
      bfha_pkg::ST_IDLE: begin
        if (cfg_acc) begin
          heap_d  = PW'(r_norm);
          state_d = bfha_pkg::ST_INIT;
        end else if (req_acc) begin
          pos_d     = '0;
          found_d   = 1'b0;
          need_d    = r_need;
          foff_d    = free_offset_i;
          res_off_d = '0;
          if (req_type_i == bfha_pkg::REQ_FREE) begin
            state_d = bfha_pkg::ST_F_RD;
          end else if (req_size_i == '0) begin
            res_st_d = bfha_pkg::STATUS_NO_FIT;
            state_d  = bfha_pkg::ST_DONE;
          end else begin
            state_d = bfha_pkg::ST_A_RD;
          end
        end
      end
      bfha_pkg::ST_A_RD: state_d = bfha_pkg::ST_A_EV;
      bfha_pkg::ST_A_EV: begin
        if (r_bad) begin
          state_d = bfha_pkg::ST_A_FIN;
        end else begin
          if (r_free && r_len >= need_q && (!found_q || r_len < CW'(blen_q))) begin
            found_d = 1'b1;
            best_d  = pos_q;
            blen_d  = PW'(r_len);
          end
          pos_d   = PW'(r_next);
          state_d = (r_next >= r_heap) ? bfha_pkg::ST_A_FIN : bfha_pkg::ST_A_RD;
        end
      end
      bfha_pkg::ST_A_FIN: begin
        if (!found_q) begin
          res_st_d = bfha_pkg::STATUS_NO_FIT;
          state_d  = bfha_pkg::ST_DONE;
        end else begin
          res_st_d  = bfha_pkg::STATUS_OK;
          res_off_d = 14'(CW'(best_q) + CW'(HEADER_BYTES));
          state_d   = (CW'(blen_q) >= need_q + CW'(MIN_SPLIT_BYTES)) ?
                      bfha_pkg::ST_A_SPLIT : bfha_pkg::ST_DONE;
        end
      end
      bfha_pkg::ST_A_SPLIT: state_d = bfha_pkg::ST_DONE;
      bfha_pkg::ST_F_RD: state_d = bfha_pkg::ST_F_EV;
      bfha_pkg::ST_F_EV: begin
        if (r_bad) begin
          res_st_d = bfha_pkg::STATUS_BAD_FREE;
          state_d  = bfha_pkg::ST_DONE;
        end else if (r_pos + CW'(HEADER_BYTES) == CW'(foff_q) && !r_free) begin
          pos_d   = '0;
          state_d = bfha_pkg::ST_C_RD;
        end else if (r_next >= r_heap) begin
          res_st_d = bfha_pkg::STATUS_BAD_FREE;
          state_d  = bfha_pkg::ST_DONE;
        end else begin
          pos_d   = PW'(r_next);
          state_d = bfha_pkg::ST_F_RD;
        end
      end
      bfha_pkg::ST_C_RD: state_d = bfha_pkg::ST_C_EV;
      bfha_pkg::ST_C_EV: begin
        res_st_d = bfha_pkg::STATUS_OK;
        if (r_bad || r_next >= r_heap) begin
          state_d = bfha_pkg::ST_DONE;
        end else if (r_free) begin
          cur_d   = PW'(r_len);
          state_d = bfha_pkg::ST_C_NX;
        end else begin
          pos_d   = PW'(r_next);
          state_d = bfha_pkg::ST_C_RD;
        end
      end
      bfha_pkg::ST_C_NX: begin
        if (!r_free) begin
          pos_d   = PW'(r_pos + CW'(cur_q));
          state_d = bfha_pkg::ST_C_RD;
        end else if (r_nbad) begin
          state_d = bfha_pkg::ST_DONE;
        end else begin
          // merged header is re-read from pos
          state_d = bfha_pkg::ST_C_RD;
        end
      end
      bfha_pkg::ST_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d = 1'b1;
          rsp_off_d   = res_off_q;
          rsp_st_d    = res_st_q;
          state_d     = bfha_pkg::ST_IDLE;
        end
      end
      default: state_d = bfha_pkg::ST_INIT;
    endcase
  end

  // store access and handshake outputs
  always_comb begin
    we    = 1'b0;
    waddr = pos_q[AW+1:2];
    wdata = {1'b1, cur_q};
    raddr = pos_q[AW+1:2];
    unique case (state_q)
      bfha_pkg::ST_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {1'b1, heap_q};
      end
      bfha_pkg::ST_A_FIN: begin
        we    = found_q;
        waddr = best_q[AW+1:2];
        wdata = (CW'(blen_q) >= need_q + CW'(MIN_SPLIT_BYTES)) ?
                {1'b0, PW'(need_q)} : {1'b0, blen_q};
      end
      bfha_pkg::ST_A_SPLIT: begin
        we    = 1'b1;
        waddr = r_split[AW+1:2];
        wdata = {1'b1, PW'(CW'(blen_q) - need_q)};
      end
      bfha_pkg::ST_F_EV: begin
        we    = !r_bad && (r_pos + CW'(HEADER_BYTES) == CW'(foff_q)) && !r_free;
        wdata = {1'b1, PW'(r_len)};
      end
      bfha_pkg::ST_C_EV: raddr = r_next[AW+1:2];
      bfha_pkg::ST_C_NX: begin
        we    = r_free && !r_nbad;
        wdata = {1'b1, PW'(CW'(cur_q) + r_len)};
      end
      default: ;
    endcase
  end

  assign req_ready_o   = (state_q == bfha_pkg::ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == bfha_pkg::ST_IDLE);
  assign rsp_valid_o   = rsp_valid_q;
  assign data_offset_o = rsp_off_q;
  assign status_o      = rsp_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfha_pkg::ST_INIT;
      heap_q      <= PW'(bfha_pkg::HEAP_FLOOR_BYTES);
      rsp_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      heap_q      <= heap_d;
      rsp_valid_q <= rsp_valid_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    cur_q     <= cur_d;
    best_q    <= best_d;
    blen_q    <= blen_d;
    need_q    <= need_d;
    res_off_q <= res_off_d;
    res_st_q  <= res_st_d;
    foff_q    <= foff_d;
    rsp_off_q <= rsp_off_d;
    rsp_st_q  <= rsp_st_d;
  end

  a_cfg_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> state_q == bfha_pkg::ST_INIT)
    else $error("config write did not rebuild heap");

  a_heap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(heap_q) >= CW'(bfha_pkg::HEAP_FLOOR_BYTES))
    && (CW'(heap_q) <= CW'(bfha_pkg::HEAP_MAX_BYTES))
    && (heap_q[1:0] == 2'b00))
    else $error("heap size out of range");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bfha_pkg::ST_IDLE |-> !we)
    else $error("store written while idle");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(state_q) == bfha_pkg::ST_DONE)
    else $error("response beat without finished request");

endmodule
